### sv/hvdi_pkg.sv
package hvdi_pkg;

	localparam int COEF_W    = 32;
	localparam int X_W       = 32;
	localparam int DEG_W     = 8;
	localparam int ACC_W     = 48;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_CNT_W = $clog2(COEF_W);

	localparam logic [CFG_IDX_W-1:0] REG_X_POINT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = 1'b1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_DERIV,
		ST_VALUE,
		ST_INTEG,
		ST_FINAL
	} seq_state_t;

	typedef enum logic [1:0] {
		MAC_IDLE,
		MAC_LO,
		MAC_HI,
		MAC_SUM
	} mac_phase_t;

endpackage

### sv/hvdi_div.sv
module hvdi_div #(
	parameter int DVS_W = 9
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [hvdi_pkg::COEF_W-1:0] dividend,
	input  logic        [DVS_W-1:0]            divisor,
	output logic                               busy,
	output logic signed [hvdi_pkg::COEF_W-1:0] quotient
);

	logic                              busy_q;
	logic [hvdi_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [DVS_W-1:0]                  rem_q;
	logic [DVS_W-1:0]                  dvs_q;
	logic [hvdi_pkg::COEF_W-1:0]       quo_q;
	logic                              neg_q;

	logic [DVS_W:0]                    trial;
	logic                              ge;
	logic [DVS_W-1:0]                  rem_n;
	logic [hvdi_pkg::COEF_W-1:0]       quo_n;
	logic [hvdi_pkg::COEF_W-1:0]       mag;

	assign mag   = dividend[hvdi_pkg::COEF_W-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[hvdi_pkg::COEF_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign rem_n = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
	assign quo_n = {quo_q[hvdi_pkg::COEF_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= hvdi_pkg::DIV_CNT_W'(hvdi_pkg::COEF_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// restoring divide on magnitudes, one quotient bit a cycle; sign fixed on the last step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[hvdi_pkg::COEF_W-1];
		end else if (busy_q) begin
			rem_q <= rem_n;
			if (cnt_q == '0) begin
				quo_q <= neg_q ? (~quo_n + 1'b1) : quo_n;
			end else begin
				quo_q <= quo_n;
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### sv/hvdi_mac.sv
module hvdi_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [hvdi_pkg::ACC_W-1:0] a,
	input  logic signed [hvdi_pkg::X_W-1:0]   x,
	input  logic signed [hvdi_pkg::ACC_W-1:0] addend,
	output logic                              busy,
	output logic signed [hvdi_pkg::ACC_W-1:0] result,
	output logic                              sat
);

	localparam int HALF_W = hvdi_pkg::ACC_W / 2;
	localparam int MUL_W  = HALF_W + 1 + hvdi_pkg::X_W;
	localparam int PROD_W = hvdi_pkg::ACC_W + hvdi_pkg::X_W;

	hvdi_pkg::mac_phase_t phase_q, phase_d;

	logic signed [hvdi_pkg::ACC_W-1:0] a_q;
	logic signed [hvdi_pkg::X_W-1:0]   x_q;
	logic signed [hvdi_pkg::ACC_W-1:0] add_q;
	logic signed [PROD_W-1:0]          prod_q;
	logic signed [hvdi_pkg::ACC_W-1:0] res_q;
	logic                              sat_q;

	logic signed [HALF_W:0]            mul_a;
	logic signed [MUL_W-1:0]           mul_p;
	logic signed [PROD_W:0]            sum_w;
	logic                              fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hvdi_pkg::MAC_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			hvdi_pkg::MAC_IDLE: if (start) phase_d = hvdi_pkg::MAC_LO;
			hvdi_pkg::MAC_LO:   phase_d = hvdi_pkg::MAC_HI;
			hvdi_pkg::MAC_HI:   phase_d = hvdi_pkg::MAC_SUM;
			hvdi_pkg::MAC_SUM:  phase_d = hvdi_pkg::MAC_IDLE;
			default:            phase_d = hvdi_pkg::MAC_IDLE;
		endcase
	end

	// low half is unsigned, high half carries the sign
	assign mul_a = (phase_q == hvdi_pkg::MAC_LO) ? $signed({1'b0, a_q[HALF_W-1:0]})
	                                             : $signed({a_q[hvdi_pkg::ACC_W-1],
	                                                        a_q[hvdi_pkg::ACC_W-1:HALF_W]});
	assign mul_p = mul_a * x_q;

	// arithmetic shift floors the scaled product
	assign sum_w = (PROD_W+1)'(prod_q >>> FRAC_BITS) + (PROD_W+1)'(add_q);
	assign fits  = (&sum_w[PROD_W:hvdi_pkg::ACC_W-1]) | ~(|sum_w[PROD_W:hvdi_pkg::ACC_W-1]);

	always_ff @(posedge clk) begin
		if (start && phase_q == hvdi_pkg::MAC_IDLE) begin
			a_q   <= a;
			x_q   <= x;
			add_q <= addend;
		end
		if (phase_q == hvdi_pkg::MAC_LO) begin
			prod_q <= PROD_W'(mul_p);
		end else if (phase_q == hvdi_pkg::MAC_HI) begin
			prod_q <= prod_q + (PROD_W'(mul_p) <<< HALF_W);
		end
		if (phase_q == hvdi_pkg::MAC_SUM) begin
			sat_q <= !fits;
			if (fits) begin
				res_q <= sum_w[hvdi_pkg::ACC_W-1:0];
			end else begin
				res_q <= sum_w[PROD_W] ? hvdi_pkg::ACC_MIN : hvdi_pkg::ACC_MAX;
			end
		end
	end

	assign busy   = phase_q != hvdi_pkg::MAC_IDLE;
	assign result = res_q;
	assign sat    = sat_q;

endmodule

### sv/horner_value_derivative_integral_unit.sv
// Horner evaluation of a polynomial, its first derivative and its integral at x_point.
// Input stream (s_*): one coefficient per transfer, highest power first; s_tlast marks
// the constant term and closes the polynomial.
// Output stream (m_*): one result per polynomial, on the transfer that carried s_tlast.
// Config port: write x_point (index 0, Q15.16) or degree (index 1) while the block idles.
// Each coefficient is worked off in full before another is taken: a 32-step restoring divide of
// the coefficient by the remaining power count, then three multiply-adds on one shared
// 25x32 multiplier (split 48x32 product), and a return to idle. A closing coefficient
// adds one more multiply-add (integral times x) before m_tvalid rises.
// s_tready is high only between items.
// Once the power count reaches zero the divide is skipped and too_many_terms is flagged.
// The result sits in an output register; a stalled receiver holds it there and the
// block keeps taking coefficients of the next polynomial until that one's result is
// ready, where it waits for the register to drain.
// Reset clears the accumulators, the flags, x_point and degree; no output is pending.
module horner_value_derivative_integral_unit #(
	parameter int MAX_DEGREE = 255,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hvdi_pkg::COEF_W-1:0]         s_tdata,   // [31:0] coefficient
	input  logic                                s_tlast,   // last_coeff
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [3*hvdi_pkg::ACC_W-1:0]        m_tdata,   // [47:0] poly_value,
	                                                       // [95:48] derivative_value,
	                                                       // [143:96] integral_value
	output logic [1:0]                          m_tuser,   // [0] saturated, [1] too_many_terms
	input  logic                                cfg_we,
	input  logic [hvdi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hvdi_pkg::CFG_W-1:0]          cfg_wdata
);

	localparam int CW = $clog2(MAX_DEGREE + 2);

	hvdi_pkg::seq_state_t state_q, state_d;

	logic signed [hvdi_pkg::X_W-1:0]    x_point_q;
	logic        [hvdi_pkg::DEG_W-1:0]  degree_q;
	logic signed [hvdi_pkg::ACC_W-1:0]  value_acc_q;
	logic signed [hvdi_pkg::ACC_W-1:0]  deriv_acc_q;
	logic signed [hvdi_pkg::ACC_W-1:0]  integ_acc_q;
	logic        [CW-1:0]               count_q;
	logic                               started_q;
	logic                               sat_q;
	logic                               excess_q;
	logic signed [hvdi_pkg::COEF_W-1:0] coef_q;
	logic                               last_q;
	logic signed [hvdi_pkg::COEF_W-1:0] term_q;
	logic                               out_valid_q;
	logic signed [hvdi_pkg::ACC_W-1:0]  poly_out_q;
	logic signed [hvdi_pkg::ACC_W-1:0]  deriv_out_q;
	logic signed [hvdi_pkg::ACC_W-1:0]  integ_out_q;
	logic                               sat_out_q;
	logic                               excess_out_q;

	logic [CW-1:0]                      cnt_load;
	logic [CW-1:0]                      cnt_eff;
	logic                               accept;
	logic                               div_start;
	logic                               div_busy;
	logic signed [hvdi_pkg::COEF_W-1:0] div_quo;
	logic                               mac_start;
	logic                               mac_busy;
	logic signed [hvdi_pkg::ACC_W-1:0]  mac_a;
	logic signed [hvdi_pkg::ACC_W-1:0]  mac_add;
	logic signed [hvdi_pkg::ACC_W-1:0]  mac_res;
	logic                               mac_sat;
	logic                               finish;

	hvdi_div #(.DVS_W(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ($signed(s_tdata)),
		.divisor  (cnt_eff),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	hvdi_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.a      (mac_a),
		.x      (x_point_q),
		.addend (mac_add),
		.busy   (mac_busy),
		.result (mac_res),
		.sat    (mac_sat)
	);

	// degree is clamped and taken only on the first coefficient
	always_comb begin
		if (int'(degree_q) > MAX_DEGREE) begin
			cnt_load = CW'(MAX_DEGREE + 1);
		end else begin
			cnt_load = CW'(int'(degree_q) + 1);
		end
	end

	assign cnt_eff  = started_q ? count_q : cnt_load;
	assign s_tready = (state_q == hvdi_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign finish   = (state_q == hvdi_pkg::ST_FINAL) && !mac_busy && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hvdi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		mac_start = 1'b0;
		mac_a     = deriv_acc_q;
		mac_add   = value_acc_q;
		unique case (state_q)
			hvdi_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (cnt_eff != '0) begin
						div_start = 1'b1;
						state_d   = hvdi_pkg::ST_DIV;
					end else begin
						mac_start = 1'b1;
						state_d   = hvdi_pkg::ST_DERIV;
					end
				end
			end
			hvdi_pkg::ST_DIV: begin
				if (!div_busy) begin
					mac_start = 1'b1;
					state_d   = hvdi_pkg::ST_DERIV;
				end
			end
			hvdi_pkg::ST_DERIV: begin
				mac_a   = value_acc_q;
				mac_add = hvdi_pkg::ACC_W'(coef_q);
				if (!mac_busy) begin
					mac_start = 1'b1;
					state_d   = hvdi_pkg::ST_VALUE;
				end
			end
			hvdi_pkg::ST_VALUE: begin
				mac_a   = integ_acc_q;
				mac_add = hvdi_pkg::ACC_W'(term_q);
				if (!mac_busy) begin
					mac_start = 1'b1;
					state_d   = hvdi_pkg::ST_INTEG;
				end
			end
			hvdi_pkg::ST_INTEG: begin
				// integral from 0 to x is the Horner integral times x once more
				mac_a   = mac_res;
				mac_add = '0;
				if (!mac_busy) begin
					if (last_q) begin
						mac_start = 1'b1;
						state_d   = hvdi_pkg::ST_FINAL;
					end else begin
						state_d = hvdi_pkg::ST_IDLE;
					end
				end
			end
			hvdi_pkg::ST_FINAL: begin
				if (finish) begin
					state_d = hvdi_pkg::ST_IDLE;
				end
			end
			default: state_d = hvdi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_point_q   <= '0;
			degree_q    <= '0;
			value_acc_q <= '0;
			deriv_acc_q <= '0;
			integ_acc_q <= '0;
			count_q     <= '0;
			started_q   <= 1'b0;
			sat_q       <= 1'b0;
			excess_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hvdi_pkg::REG_X_POINT: x_point_q <= cfg_wdata[hvdi_pkg::X_W-1:0];
					hvdi_pkg::REG_DEGREE:  degree_q  <= cfg_wdata[hvdi_pkg::DEG_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				started_q <= 1'b1;
				if (cnt_eff == '0) begin
					excess_q <= 1'b1;
				end else begin
					count_q <= cnt_eff - 1'b1;
				end
			end
			if (!mac_busy) begin
				if (state_q == hvdi_pkg::ST_DERIV) begin
					deriv_acc_q <= mac_res;
					sat_q       <= sat_q | mac_sat;
				end
				if (state_q == hvdi_pkg::ST_VALUE) begin
					value_acc_q <= mac_res;
					sat_q       <= sat_q | mac_sat;
				end
				if (state_q == hvdi_pkg::ST_INTEG) begin
					integ_acc_q <= mac_res;
					sat_q       <= sat_q | mac_sat;
				end
			end
			if (out_valid_q && m_tready && !finish) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				value_acc_q <= '0;
				deriv_acc_q <= '0;
				integ_acc_q <= '0;
				count_q     <= '0;
				started_q   <= 1'b0;
				sat_q       <= 1'b0;
				excess_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			coef_q <= $signed(s_tdata);
			last_q <= s_tlast;
			term_q <= '0;
		end
		if (state_q == hvdi_pkg::ST_DIV && !div_busy) begin
			term_q <= div_quo;
		end
		if (finish) begin
			poly_out_q   <= value_acc_q;
			deriv_out_q  <= deriv_acc_q;
			integ_out_q  <= mac_res;
			sat_out_q    <= sat_q | mac_sat;
			excess_out_q <= excess_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {integ_out_q, deriv_out_q, poly_out_q};
	assign m_tuser  = {excess_out_q, sat_out_q};

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hvdi_pkg::ST_IDLE) |-> (!mac_busy && !div_busy))
		else $error("shared units busy while waiting for a coefficient");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == hvdi_pkg::ST_FINAL))
		else $error("result raised outside the closing step");

	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (!started_q && value_acc_q == '0 && !sat_q && !excess_q))
		else $error("polynomial state not cleared after result");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == hvdi_pkg::ST_DIV))
		else $error("divider running outside its step");

endmodule
